// ----- src/fpes_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Flash program/erase sequencer package
// Shared types, codes and constants of the sequencer front end, queue and
// bus-cycle generator.
// ----------------------------------------------------------------------------
package fpes_pkg;

  localparam int ADDR_BITS = 16;
  localparam logic [15:0] ADDR_MASK =
    (ADDR_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << ADDR_BITS) - 32'd1);

  // Input command codes.
  localparam logic [2:0] CMD_PROGRAM      = 3'd0;
  localparam logic [2:0] CMD_ERASE_BEGIN  = 3'd1;
  localparam logic [2:0] CMD_ERASE_VERIFY = 3'd2;
  localparam logic [2:0] CMD_READ         = 3'd3;
  localparam logic [2:0] CMD_RESPONSE     = 3'd4;

  // Result bus operations.
  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_REPORT = 2'd2;

  // Report status codes.
  localparam logic [1:0] ST_PASS = 2'd0;
  localparam logic [1:0] ST_FAIL = 2'd1;
  localparam logic [1:0] ST_BUSY = 2'd2;

  // Flash command bytes.
  localparam logic [7:0] FL_PROGRAM = 8'h40;
  localparam logic [7:0] FL_VERIFY  = 8'h0C;
  localparam logic [7:0] FL_ERASE   = 8'h20;
  localparam logic [7:0] FL_BLANK   = 8'hFF;

  // Configuration register indexes.
  localparam logic [2:0] REG_MAX_PROGRAM_TRIES = 3'd0;
  localparam logic [2:0] REG_MAX_ERASE_PULSES  = 3'd1;
  localparam logic [2:0] REG_PROGRAM_HOLD_US   = 3'd2;
  localparam logic [2:0] REG_VERIFY_HOLD_US    = 3'd3;
  localparam logic [2:0] REG_ERASE_HOLD_US     = 3'd4;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_PROG,
    PH_ERASE,
    PH_READ
  } phase_t;

  typedef enum logic [2:0] {
    JOB_PROGRAM,
    JOB_ERASE_ARM,
    JOB_ERASE_READ,
    JOB_READ,
    JOB_REPORT
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [15:0] address;
    logic [7:0]  data;
    logic [1:0]  status;
  } job_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] address;
    logic [7:0]  write_value;
    logic [7:0]  device_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  bus_op;
    logic [15:0] bus_address;
    logic [7:0]  bus_data;
    logic        strobe_us;
    logic [15:0] hold_us;
    logic [1:0]  status;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  max_program_tries;
    logic [7:0]  max_erase_pulses;
    logic [7:0]  program_hold_us;
    logic [7:0]  verify_hold_us;
    logic [15:0] erase_hold_us;
  } cfg_t;

endpackage
`default_nettype wire

// ----- src/fpes_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Sequencer front end
// Accepts commands, tracks the program/erase state and turns each command
// into at most one bus-cycle or report job for the back end.
// ----------------------------------------------------------------------------
module fpes_front (
  input  wire                 clk,
  input  wire                 rst,
  input  wire fpes_pkg::cfg_t cfg,
  input  wire                 accept,
  input  wire fpes_pkg::in_item_t item,
  output logic                push,
  output fpes_pkg::job_t      job
);
  import fpes_pkg::*;

  phase_t      phase, phase_next;
  logic [7:0]  try_count, try_count_next;
  logic [7:0]  erase_pulse_count, erase_pulse_count_next;
  logic        erase_armed, erase_armed_next;
  logic [15:0] held_address, held_address_next;
  logic [7:0]  held_value, held_value_next;

  logic [15:0] adr;
  logic        busy;
  logic [7:0]  pulse_inc;

  assign adr       = item.address & ADDR_MASK;
  assign busy      = (item.command <= CMD_READ) && (phase != PH_IDLE);
  assign pulse_inc = (erase_pulse_count == 8'hFF) ? erase_pulse_count
                                                  : erase_pulse_count + 8'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_IDLE;
      try_count         <= 8'd0;
      erase_pulse_count <= 8'd0;
      erase_armed       <= 1'b1;
      held_address      <= 16'd0;
      held_value        <= 8'd0;
    end else if (accept) begin
      phase             <= phase_next;
      try_count         <= try_count_next;
      erase_pulse_count <= erase_pulse_count_next;
      erase_armed       <= erase_armed_next;
      held_address      <= held_address_next;
      held_value        <= held_value_next;
    end
  end

  // Next state.
  always_comb begin
    phase_next             = phase;
    try_count_next         = try_count;
    erase_pulse_count_next = erase_pulse_count;
    erase_armed_next       = erase_armed;
    held_address_next      = held_address;
    held_value_next        = held_value;
    if (!busy) begin
      case (item.command)
        CMD_PROGRAM: begin
          held_address_next = adr;
          held_value_next   = item.write_value;
          try_count_next    = 8'd1;
          phase_next        = PH_PROG;
        end
        CMD_ERASE_BEGIN: begin
          erase_pulse_count_next = 8'd0;
          erase_armed_next       = 1'b1;
        end
        CMD_ERASE_VERIFY: begin
          held_address_next = adr;
          erase_armed_next  = 1'b0;
          phase_next        = PH_ERASE;
        end
        CMD_READ: begin
          held_address_next = adr;
          phase_next        = PH_READ;
        end
        CMD_RESPONSE: begin
          case (phase)
            PH_PROG: begin
              if (item.device_value == held_value || try_count >= cfg.max_program_tries) begin
                phase_next = PH_IDLE;
              end else begin
                try_count_next = try_count + 8'd1;
              end
            end
            PH_ERASE: begin
              if (item.device_value == FL_BLANK) begin
                phase_next = PH_IDLE;
              end else begin
                erase_pulse_count_next = pulse_inc;
                if (pulse_inc >= cfg.max_erase_pulses) begin
                  erase_armed_next = 1'b1;
                  phase_next       = PH_IDLE;
                end else begin
                  // Re-armed and the arming cycles go out right away.
                  erase_armed_next = 1'b0;
                end
              end
            end
            PH_READ: phase_next = PH_IDLE;
            default: phase_next = phase;
          endcase
        end
        default: phase_next = phase;
      endcase
    end
  end

  // Job for the back end.
  always_comb begin
    push        = 1'b0;
    job.kind    = JOB_REPORT;
    job.address = adr;
    job.data    = 8'd0;
    job.status  = ST_PASS;
    if (busy) begin
      push       = accept;
      job.status = ST_BUSY;
    end else begin
      case (item.command)
        CMD_PROGRAM: begin
          push     = accept;
          job.kind = JOB_PROGRAM;
          job.data = item.write_value;
        end
        CMD_ERASE_BEGIN: push = accept;
        CMD_ERASE_VERIFY: begin
          push     = accept;
          job.kind = erase_armed ? JOB_ERASE_ARM : JOB_ERASE_READ;
        end
        CMD_READ: begin
          push     = accept;
          job.kind = JOB_READ;
        end
        CMD_RESPONSE: begin
          job.address = held_address;
          job.data    = item.device_value;
          case (phase)
            PH_PROG: begin
              push = accept;
              if (item.device_value == held_value) begin
                job.status = ST_PASS;
              end else if (try_count >= cfg.max_program_tries) begin
                job.status = ST_FAIL;
              end else begin
                job.kind = JOB_PROGRAM;
                job.data = held_value;
              end
            end
            PH_ERASE: begin
              push = accept;
              if (item.device_value == FL_BLANK) begin
                job.status = ST_PASS;
              end else if (pulse_inc >= cfg.max_erase_pulses) begin
                job.status = ST_FAIL;
              end else begin
                job.kind = JOB_ERASE_ARM;
              end
            end
            PH_READ: push = accept;
            default: push = 1'b0;
          endcase
        end
        default: push = 1'b0;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- src/fpes_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Job queue
// Two-entry queue that decouples the command front end from the bus-cycle
// generator.
// ----------------------------------------------------------------------------
module fpes_queue (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 push,
  input  wire fpes_pkg::job_t push_job,
  output logic                full,
  input  wire                 pop,
  output logic                head_valid,
  output fpes_pkg::job_t      head_job
);
  import fpes_pkg::*;

  job_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_job   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

// ----- src/fpes_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Bus-cycle generator
// Expands the job at the head of the queue into its bus cycles or report,
// one result per cycle while out_ready allows, through a registered output stage.
// ----------------------------------------------------------------------------
module fpes_back (
  input  wire                  clk,
  input  wire                  rst,
  input  wire fpes_pkg::cfg_t  cfg,
  input  wire                  head_valid,
  input  wire fpes_pkg::job_t  head_job,
  output logic                 pop,
  output logic                 out_valid,
  input  wire                  out_ready,
  output fpes_pkg::out_item_t  out_item
);
  import fpes_pkg::*;

  logic [1:0] idx;
  logic [1:0] final_idx;
  logic       load;
  logic       emit;
  out_item_t  item;

  assign load = !out_valid || out_ready;
  assign emit = head_valid && load;
  assign pop  = emit && (idx == final_idx);

  always_comb begin
    case (head_job.kind)
      JOB_PROGRAM:   final_idx = 2'd3;
      JOB_ERASE_ARM: final_idx = 2'd2;
      default:       final_idx = 2'd0;
    endcase
  end

  always_comb begin
    item.bus_op      = OP_READ;
    item.bus_address = head_job.address;
    item.bus_data    = 8'd0;
    item.strobe_us   = 1'b0;
    item.hold_us     = 16'd0;
    item.status      = ST_PASS;
    item.last        = (idx == final_idx);
    case (head_job.kind)
      JOB_PROGRAM: begin
        case (idx)
          2'd0: begin
            item.bus_op    = OP_WRITE;
            item.bus_data  = FL_PROGRAM;
            item.strobe_us = 1'b1;
            item.hold_us   = 16'd1;
          end
          2'd1: begin
            item.bus_op    = OP_WRITE;
            item.bus_data  = head_job.data;
            item.strobe_us = 1'b1;
            item.hold_us   = {8'd0, cfg.program_hold_us};
          end
          2'd2: begin
            item.bus_op    = OP_WRITE;
            item.bus_data  = FL_VERIFY;
            item.strobe_us = 1'b1;
            item.hold_us   = {8'd0, cfg.verify_hold_us};
          end
          default: item.bus_op = OP_READ;
        endcase
      end
      JOB_ERASE_ARM: begin
        case (idx)
          2'd0: begin
            item.bus_op    = OP_WRITE;
            item.bus_data  = FL_ERASE;
            item.strobe_us = 1'b1;
            item.hold_us   = 16'd1;
          end
          2'd1: begin
            item.bus_op    = OP_WRITE;
            item.bus_data  = FL_ERASE;
            item.strobe_us = 1'b1;
            item.hold_us   = cfg.erase_hold_us;
          end
          default: item.hold_us = {8'd0, cfg.verify_hold_us};
        endcase
      end
      JOB_ERASE_READ: item.hold_us = {8'd0, cfg.verify_hold_us};
      JOB_READ:       item.hold_us = 16'd1;
      default: begin
        item.bus_op   = OP_REPORT;
        item.bus_data = head_job.data;
        item.status   = head_job.status;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= 2'd0;
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
      idx       <= pop ? 2'd0 : idx + 2'd1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_item <= item;
    end
  end

  a_report_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.bus_op == OP_REPORT |-> out_item.last)
    else $error("report result not marked last");

  a_strobe_on_writes_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.bus_op != OP_WRITE |-> !out_item.strobe_us)
    else $error("strobe on a non-write result");

  a_status_on_reports_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.bus_op != OP_REPORT |-> out_item.status == ST_PASS)
    else $error("status set on a bus cycle");

  a_burst_holds_head: assert property (@(posedge clk) disable iff (rst)
    idx != 2'd0 |-> head_valid)
    else $error("job left the queue in the middle of its burst");

endmodule
`default_nettype wire

// ----- src/flash_program_erase_sequencer_unit.sv -----
// With the queue empty, an accepted command is first written into the job queue, and its first
// result is then registered from the queue head into out_item.
// Throughput: one result per cycle while out_ready allows; a program job gives four, an
// erase-arming job three, every other job one, and a response in the idle phase none.
// The two-entry job queue lets new commands in while an earlier burst is still going out.
// Reset (rst, synchronous): idle phase, counters zero, erase armed, registers to their defaults.
`default_nettype none
// ----------------------------------------------------------------------------
// Flash program/erase sequencer
// Quick-pulse byte program and erase verify sequencing with retry, driving
// a stream of flash bus cycles and completion reports.
// ----------------------------------------------------------------------------
module flash_program_erase_sequencer_unit (
  input  wire                      clk,
  input  wire                      rst,
  // Configuration port.
  input  wire                      psel,
  input  wire                      penable,
  input  wire                      pwrite,
  input  wire  [4:0]               paddr,
  input  wire  [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  // Command channel.
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire fpes_pkg::in_item_t  in_item,
  // Result channel.
  output logic                     out_valid,
  input  wire                      out_ready,
  output fpes_pkg::out_item_t      out_item
);
  import fpes_pkg::*;

  cfg_t       cfg;
  logic       cfg_write;
  logic [2:0] reg_index;

  logic       accept;
  logic       push;
  job_t       push_job;
  logic       full;
  logic       pop;
  logic       head_valid;
  job_t       head_job;

  // The register file. Each register sits at a word address; the two low
  // address bits are ignored and writes beyond the list are dropped.
  assign pready    = 1'b1;
  assign reg_index = paddr[4:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_program_tries <= 8'd25;
      cfg.max_erase_pulses  <= 8'd25;
      cfg.program_hold_us   <= 8'd10;
      cfg.verify_hold_us    <= 8'd6;
      cfg.erase_hold_us     <= 16'd10000;
    end else if (cfg_write) begin
      case (reg_index)
        REG_MAX_PROGRAM_TRIES: cfg.max_program_tries <= pwdata[7:0];
        REG_MAX_ERASE_PULSES:  cfg.max_erase_pulses  <= pwdata[7:0];
        REG_PROGRAM_HOLD_US:   cfg.program_hold_us   <= pwdata[7:0];
        REG_VERIFY_HOLD_US:    cfg.verify_hold_us    <= pwdata[7:0];
        REG_ERASE_HOLD_US:     cfg.erase_hold_us     <= pwdata[15:0];
        default:               cfg.erase_hold_us     <= cfg.erase_hold_us;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_MAX_PROGRAM_TRIES: prdata = {24'd0, cfg.max_program_tries};
      REG_MAX_ERASE_PULSES:  prdata = {24'd0, cfg.max_erase_pulses};
      REG_PROGRAM_HOLD_US:   prdata = {24'd0, cfg.program_hold_us};
      REG_VERIFY_HOLD_US:    prdata = {24'd0, cfg.verify_hold_us};
      REG_ERASE_HOLD_US:     prdata = {16'd0, cfg.erase_hold_us};
      default:               prdata = 32'd0;
    endcase
  end

  // A command transaction is taken whenever the queue has room, so a
  // command that causes no result still needs a free slot to be accepted.
  // That keeps the front end free of any look at the output side.
  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  // Front end: holds the phase, retry and pulse counters and the latched
  // address and byte, and classifies each command into at most one job.
  fpes_front u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .accept (accept),
    .item   (in_item),
    .push   (push),
    .job    (push_job)
  );

  // The queue lets the front end move on to the next command while the
  // back end is still sending out a burst of bus cycles.
  fpes_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // Back end: one result transaction per cycle from the head job while out_ready allows, with
  // hold times from live registers that the user must change only when idle (not enforced here).
  fpes_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item)
  );

endmodule
`default_nettype wire
